>>> hdl/ctd_pkg.sv
// Shared types, constants and register codes for the crank trigger decoder.
package ctd_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int IN_W  = 88;
  localparam int OUT_W = 152;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DECODER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOOTH_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_TEETH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGES_PER_TOOTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INJ_MIN_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INJ_MAX_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_MIN_TIME  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_MAX_TIME  = 3'd7;

  localparam logic MODE_MISSING_TOOTH = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ANG_START,
    ST_ANG_WAIT,
    ST_MUL,
    ST_TIME_START,
    ST_TIME_WAIT,
    ST_RESULT,
    ST_HOLD
  } ctd_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic ang_take;
    logic mul;
    logic time_start;
    logic time_take;
    logic out_load;
  } ctd_cmd_t;

  typedef struct packed {
    logic sched;
    logic div_done;
    logic time_done;
  } ctd_status_t;

endpackage

>>> hdl/crank_trigger_decoder_scheduler_core.sv
// Top level of the crank trigger decoder and injection/ignition scheduler.
//
//  Channel  Dir  Signals                       Contents
//  s_*      in   tvalid tready tdata[87:0]     one crank edge item
//  m_*      out  tvalid tready tdata tuser     one decode and schedule item
//  cfg_*    in   valid ready index data        register writes
//
// An edge without a schedule passes through the EVAL and RESULT states before it is offered.
// A scheduled edge also runs the dwell angle divider, which gives one quotient bit per cycle
// over TIME_BITS+9 bits, and the divide by 360 of the spark time, which gives one 16-bit digit
// per cycle.
// One item is in flight; a stalled result holds the block, and the next item is taken
// in the cycle after the result is taken. Reset restores register defaults and the decoder.
module crank_trigger_decoder_scheduler_core #(
  parameter int TIME_BITS = ctd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // edge_time[31:0], pulse_width_one[47:32], pulse_width_two[63:48],
  // spark_advance[71:64], dwell_request[87:72]
  input  logic [ctd_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // edge_accepted[0], in_sync[1], rev_period[33:2], inj_bank[34],
  // inj_delay[66:35], inj_width[82:67], ign_coil[83], ign_delay[115:84],
  // ign_dwell[147:116], zero fill[151:148]
  output logic [ctd_pkg::OUT_W-1:0]       m_tdata,
  // schedule_valid[0]
  output logic                            m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ctd_pkg::*;

  ctd_cmd_t    cmd;
  ctd_status_t status;

  assign cfg_ready = 1'b1;

  ctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ctd_dp #(.TIME_BITS(TIME_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  a_no_accept_while_holding: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !m_tvalid)
    else $error("item accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready stayed high after an accepted item");

  a_schedule_needs_sync: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[0] && m_tdata[1]))
    else $error("schedule issued without an accepted edge in sync");

  a_div_start_clears_done: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider reported done right after a start");
endmodule

>>> hdl/ctd_div.sv
// Dividers: a restoring divider with one quotient bit per cycle, and a divide-by-360 unit.
module ctd_div #(
  parameter int NW = 41,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign shifted  = {rem, quo[NW-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign diff     = shifted - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end
endmodule

// Divides by 360 one 16-bit digit per cycle, each digit by reciprocal multiplication.
module ctd_div360 #(
  parameter int NW = 41
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  output logic [NW-1:0] quotient,
  output logic          done
);
  localparam int ND = (NW + 15) / 16;
  localparam int XW = ND * 16;
  localparam int CW = $clog2(ND + 1);
  // ceil(2^34 / 360); exact for every partial value below 360 * 2^16.
  localparam logic [25:0] RECIP = 26'd47721859;

  logic [XW-1:0] xr, qr;
  logic [8:0]    rr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [24:0]   val;
  logic [49:0]   prod;
  logic [15:0]   qd;
  logic [8:0]    rem;

  assign val      = {rr, xr[XW-1 -: 16]};
  assign prod     = 50'(val) * 50'(RECIP);
  assign qd       = prod[49:34];
  assign rem      = 9'(val - 25'(qd) * 25'd360);
  assign quotient = qr[NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(ND);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= XW'(dividend);
      qr <= '0;
      rr <= '0;
    end else if (busy) begin
      xr <= {xr[XW-17:0], 16'd0};
      qr <= {qr[XW-17:0], qd};
      rr <= rem;
    end
  end
endmodule

>>> hdl/ctd_ctrl.sv
// Controller state machine that sequences decode, division and result hand-off.
module ctd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  ctd_pkg::ctd_status_t status,
  output ctd_pkg::ctd_cmd_t   cmd
);
  import ctd_pkg::*;

  ctd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (s_tvalid) state_next = ST_EVAL;
      ST_EVAL:       state_next = status.sched ? ST_ANG_START : ST_RESULT;
      ST_ANG_START:  state_next = ST_ANG_WAIT;
      ST_ANG_WAIT:   if (status.div_done) state_next = ST_MUL;
      ST_MUL:        state_next = ST_TIME_START;
      ST_TIME_START: state_next = ST_TIME_WAIT;
      ST_TIME_WAIT:  if (status.time_done) state_next = ST_RESULT;
      ST_RESULT:     state_next = ST_HOLD;
      ST_HOLD:       if (m_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_EVAL:       cmd.eval = 1'b1;
      ST_ANG_START:  cmd.div_start = 1'b1;
      ST_ANG_WAIT:   cmd.ang_take = status.div_done;
      ST_MUL:        cmd.mul = 1'b1;
      ST_TIME_START: cmd.time_start = 1'b1;
      ST_TIME_WAIT:  cmd.time_take = status.time_done;
      ST_RESULT:     cmd.out_load = 1'b1;
      ST_HOLD:       m_tvalid = 1'b1;
      default:       cmd = '0;
    endcase
  end
endmodule

>>> hdl/ctd_dp.sv
// Datapath: configuration, decoder state, schedule arithmetic and result register.
module ctd_dp #(
  parameter int TIME_BITS = ctd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ctd_pkg::ctd_cmd_t               cmd,
  output ctd_pkg::ctd_status_t            status,
  input  logic [ctd_pkg::IN_W-1:0]        s_tdata,
  input  logic                            cfg_valid,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [ctd_pkg::OUT_W-1:0]       m_tdata,
  output logic                            m_tuser
);
  import ctd_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int NW = TB + 9;
  localparam int IW = TB + 2;

  // Configuration registers.
  logic        decoder_mode;
  logic [7:0]  tooth_count;
  logic [3:0]  missing_teeth;
  logic [1:0]  edges_per_tooth;
  logic [15:0] inj_min_width, inj_max_width, dwell_min_time, dwell_max_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_mode    <= MODE_MISSING_TOOTH;
      tooth_count     <= 8'd36;
      missing_teeth   <= 4'd1;
      edges_per_tooth <= 2'd2;
      inj_min_width   <= 16'd500;
      inj_max_width   <= 16'd20000;
      dwell_min_time  <= 16'd1500;
      dwell_max_time  <= 16'd6000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DECODER_MODE:    decoder_mode    <= cfg_data[0];
        REG_TOOTH_COUNT:     tooth_count     <= cfg_data[7:0];
        REG_MISSING_TEETH:   missing_teeth   <= cfg_data[3:0];
        REG_EDGES_PER_TOOTH: edges_per_tooth <= cfg_data[1:0];
        REG_INJ_MIN_WIDTH:   inj_min_width   <= cfg_data;
        REG_INJ_MAX_WIDTH:   inj_max_width   <= cfg_data;
        REG_DWELL_MIN_TIME:  dwell_min_time  <= cfg_data;
        REG_DWELL_MAX_TIME:  dwell_max_time  <= cfg_data;
        default:             decoder_mode    <= decoder_mode;
      endcase
    end
  end

  // Captured input item.
  logic [TB-1:0]     now;
  logic [15:0]       pw_one, pw_two, dwell_req;
  logic signed [7:0] advance;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now       <= TB'(s_tdata[31:0]);
      pw_one    <= s_tdata[47:32];
      pw_two    <= s_tdata[63:48];
      advance   <= s_tdata[71:64];
      dwell_req <= s_tdata[87:72];
    end
  end

  // Decoder state.
  logic [TB-1:0] last_edge_time, last_gap_time, last_sync_time, revolution_period;
  logic [15:0]   pulse_count;
  logic          sync_flag, bank_toggle, sync_time_valid;
  logic [7:0]    sync_loss_count;

  logic [TB-1:0] last_edge_time_next, last_gap_time_next, last_sync_time_next;
  logic [TB-1:0] revolution_period_next;
  logic [15:0]   pulse_count_next;
  logic          sync_flag_next, bank_toggle_next, sync_time_valid_next;
  logic [7:0]    sync_loss_count_next;
  logic          accepted, sched;

  logic [TB-1:0] gap, base, over;
  logic [15:0]   pc_inc;
  logic [7:0]    actual;
  logic [9:0]    expected;
  logic [10:0]   lo, hi;
  logic          is_gap, in_window;

  always_comb begin
    gap      = now - last_edge_time;
    base     = (last_gap_time != '0) ? last_gap_time : gap;
    over     = gap - base;
    is_gap   = (gap > base) && (over > (base >> 1));
    pc_inc   = pulse_count + 16'd1;
    actual   = (tooth_count > {4'd0, missing_teeth}) ?
               tooth_count - {4'd0, missing_teeth} : 8'd0;
    expected = {2'd0, actual} * {8'd0, edges_per_tooth};
    lo       = (expected > 10'd10) ? {1'b0, expected} - 11'd10 : 11'd0;
    hi       = {1'b0, expected} + 11'd10;
    in_window = (pc_inc >= {5'd0, lo}) && (pc_inc <= {5'd0, hi});

    last_edge_time_next    = last_edge_time;
    last_gap_time_next     = last_gap_time;
    last_sync_time_next    = last_sync_time;
    revolution_period_next = revolution_period;
    pulse_count_next       = pulse_count;
    sync_flag_next         = sync_flag;
    bank_toggle_next       = bank_toggle;
    sync_time_valid_next   = sync_time_valid;
    sync_loss_count_next   = sync_loss_count;
    accepted               = 1'b0;
    sched                  = 1'b0;

    if (decoder_mode == MODE_MISSING_TOOTH) begin
      if (gap >= TB'(50)) begin
        accepted            = 1'b1;
        last_edge_time_next = now;
        pulse_count_next    = pc_inc;
        last_gap_time_next  = gap;
        if (is_gap) begin
          pulse_count_next = 16'd1;
          if (in_window) begin
            sync_flag_next       = 1'b1;
            sync_loss_count_next = 8'd0;
            if (sync_time_valid) revolution_period_next = now - last_sync_time;
            last_sync_time_next  = now;
            sync_time_valid_next = 1'b1;
            bank_toggle_next     = !bank_toggle;
            sched                = (revolution_period_next != '0);
          end else begin
            if (sync_loss_count != 8'd255) sync_loss_count_next = sync_loss_count + 8'd1;
            if (sync_loss_count_next > 8'd10) sync_flag_next = 1'b0;
          end
        end
      end
    end else begin
      if (gap >= TB'(500)) begin
        accepted               = 1'b1;
        sync_flag_next         = 1'b1;
        pulse_count_next       = 16'd1;
        revolution_period_next = gap;
        last_edge_time_next    = now;
        last_sync_time_next    = now;
        sync_time_valid_next   = 1'b1;
        bank_toggle_next       = !bank_toggle;
        sched                  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time    <= '0;
      last_gap_time     <= '0;
      last_sync_time    <= '0;
      revolution_period <= '0;
      pulse_count       <= '0;
      sync_flag         <= 1'b0;
      bank_toggle       <= 1'b0;
      sync_time_valid   <= 1'b0;
      sync_loss_count   <= '0;
    end else if (cmd.eval) begin
      last_edge_time    <= last_edge_time_next;
      last_gap_time     <= last_gap_time_next;
      last_sync_time    <= last_sync_time_next;
      revolution_period <= revolution_period_next;
      pulse_count       <= pulse_count_next;
      sync_flag         <= sync_flag_next;
      bank_toggle       <= bank_toggle_next;
      sync_time_valid   <= sync_time_valid_next;
      sync_loss_count   <= sync_loss_count_next;
    end
  end

  // Schedule arithmetic.
  logic          acc_r, sched_r;
  logic [15:0]   pw_r, dclamp_r;
  logic [TB-1:0] dwell_r;
  logic [7:0]    dang_r;
  logic [NW-1:0] prod_r;
  logic [31:0]   ign_delay_r;

  logic [15:0]   pw_sel, pw_ok, d_lo, d_clamp;
  logic [24:0]   dw360;
  logic [8:0]    spark, ang;
  logic [NW-1:0] dividend, quotient, t_quotient;
  logic [TB-1:0] divisor;
  logic          div_done, time_done;
  logic [IW-1:0] inj_t;
  logic [OUT_W-1:0] out_next;

  always_comb begin
    pw_sel  = bank_toggle_next ? pw_two : pw_one;
    pw_ok   = (pw_sel < inj_min_width || pw_sel > inj_max_width) ? inj_min_width : pw_sel;
    d_lo    = (dwell_req < dwell_min_time) ? dwell_min_time : dwell_req;
    d_clamp = (d_lo > dwell_max_time) ? dwell_max_time : d_lo;
    dw360   = {9'd0, dclamp_r} * 25'd360;
    spark   = (advance > 8'sd0) ? 9'd360 - {1'b0, advance} : 9'd360;
    ang     = spark - {1'b0, dang_r};
    dividend = NW'(dw360);
    divisor  = revolution_period;
    inj_t    = IW'(revolution_period >> 2) * IW'(3) +
               IW'(({2'd0, revolution_period[1:0]} * 4'd3) >> 2);
  end

  ctd_div #(.NW(NW), .DW(TB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  ctd_div360 #(.NW(NW)) u_div360 (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.time_start),
    .dividend (prod_r),
    .quotient (t_quotient),
    .done     (time_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      acc_r    <= accepted;
      sched_r  <= sched;
      pw_r     <= pw_ok;
      dclamp_r <= d_clamp;
      dwell_r  <= TB'(d_clamp);
    end
    if (cmd.ang_take) begin
      if (quotient > NW'(180)) begin
        dang_r  <= 8'd180;
        dwell_r <= revolution_period >> 1;
      end else begin
        dang_r  <= quotient[7:0];
      end
    end
    if (cmd.mul) prod_r <= NW'(ang) * NW'(revolution_period);
    if (cmd.time_take) ign_delay_r <= 32'(t_quotient);
  end

  always_comb begin
    out_next        = '0;
    out_next[0]     = acc_r;
    out_next[1]     = sync_flag;
    out_next[33:2]  = 32'(revolution_period);
    if (sched_r) begin
      out_next[34]      = bank_toggle;
      out_next[66:35]   = 32'(inj_t);
      out_next[82:67]   = pw_r;
      out_next[83]      = bank_toggle;
      out_next[115:84]  = ign_delay_r;
      out_next[147:116] = 32'(dwell_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_next;
      m_tuser <= sched_r;
    end
  end

  assign status.sched     = sched;
  assign status.div_done  = div_done;
  assign status.time_done = time_done;
endmodule

>>> dv/crank_trigger_decoder_scheduler_checker.sv
// Checker for the crank trigger decoder: tracks register writes and edges, predicts and compares.
module crank_trigger_decoder_scheduler_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ctd_pkg::IN_W-1:0]        s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ctd_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            m_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending
);
  import ctd_pkg::*;

  typedef struct {
    bit        accepted;
    bit        in_sync;
    bit [31:0] rev_period;
    bit        sched;
    bit        bank;
    bit [31:0] inj_delay;
    bit [15:0] inj_width;
    bit        coil;
    bit [31:0] ign_delay;
    bit [31:0] ign_dwell;
  } decode_result_t;

  decode_result_t schedule_q[$];

  bit        mode;
  bit [7:0]  tooth_cnt;
  bit [3:0]  miss_cnt;
  bit [1:0]  ept;
  bit [15:0] inj_min, inj_max, dwell_lo, dwell_hi;

  bit [31:0] last_edge, last_gap, last_sync, rev_per;
  bit [15:0] pulses;
  bit        synced, bank_sel, sync_seen;
  bit [7:0]  loss_cnt;
  int        err_cnt;

  task automatic decode_edge(input logic [IN_W-1:0] d, output decode_result_t r);
    bit [31:0] now, gap, base;
    longint unsigned actual, expct, lo, rev, pw, dwell, dang, spark, ang;
    int adv;
    bit sched;
    now = d[31:0];
    gap = now - last_edge;
    sched = 0;
    r = '{default: 0};
    if (mode == MODE_MISSING_TOOTH) begin
      if (gap >= 50) begin
        base = (last_gap > 0) ? last_gap : gap;
        r.accepted = 1;
        last_edge = now;
        pulses = pulses + 16'd1;
        if (gap > base && (gap - base) > (base >> 1)) begin
          actual = (tooth_cnt > miss_cnt) ? tooth_cnt - miss_cnt : 0;
          expct = actual * ept;
          lo = (expct > 10) ? expct - 10 : 0;
          if (pulses >= lo && pulses <= expct + 10) begin
            synced = 1;
            loss_cnt = 0;
            if (sync_seen) rev_per = now - last_sync;
            last_sync = now;
            sync_seen = 1;
            pulses = 1;
            bank_sel = !bank_sel;
            sched = rev_per > 0;
          end else begin
            pulses = 1;
            if (loss_cnt < 255) loss_cnt++;
            if (loss_cnt > 10) synced = 0;
          end
        end
        last_gap = gap;
      end
    end else if (gap >= 500) begin
      r.accepted = 1;
      synced = 1;
      pulses = 1;
      rev_per = gap;
      last_edge = now;
      last_sync = now;
      sync_seen = 1;
      bank_sel = !bank_sel;
      sched = 1;
    end
    if (sched) begin
      rev = rev_per;
      pw = bank_sel ? d[63:48] : d[47:32];
      if (pw < inj_min || pw > inj_max) pw = inj_min;
      dwell = d[87:72];
      if (dwell < dwell_lo) dwell = dwell_lo;
      if (dwell > dwell_hi) dwell = dwell_hi;
      dang = (dwell * 360) / rev;
      if (dang > 180) begin
        dang = 180;
        dwell = rev / 2;
      end
      adv = $signed(d[71:64]);
      spark = (adv > 0) ? 360 - adv : 360;
      ang = spark - dang;
      r.sched = 1;
      r.bank = bank_sel;
      r.inj_delay = 32'(3 * (rev >> 2) + ((3 * (rev & 3)) >> 2));
      r.inj_width = 16'(pw);
      r.coil = bank_sel;
      r.ign_delay = 32'(ang * (rev / 360) + (ang * (rev % 360)) / 360);
      r.ign_dwell = 32'(dwell);
    end
    r.in_sync = synced;
    r.rev_period = rev_per;
  endtask

  task automatic compare_field(input string name, input bit [31:0] exp_v, input bit [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    decode_result_t e, p;
    if (rst) begin
      mode = 0; tooth_cnt = 36; miss_cnt = 1; ept = 2;
      inj_min = 500; inj_max = 20000; dwell_lo = 1500; dwell_hi = 6000;
      last_edge = 0; last_gap = 0; last_sync = 0; rev_per = 0;
      pulses = 0; synced = 0; bank_sel = 0; sync_seen = 0; loss_cnt = 0;
      schedule_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (schedule_q.size() == 0) begin
          $error("result item with no expectation waiting");
          err_cnt++;
        end else begin
          e = schedule_q.pop_front();
          compare_field("edge_accepted", e.accepted, m_tdata[0]);
          compare_field("in_sync", e.in_sync, m_tdata[1]);
          compare_field("rev_period", e.rev_period, m_tdata[33:2]);
          compare_field("schedule_valid", e.sched, m_tuser);
          compare_field("inj_bank", e.bank, m_tdata[34]);
          compare_field("inj_delay", e.inj_delay, m_tdata[66:35]);
          compare_field("inj_width", e.inj_width, m_tdata[82:67]);
          compare_field("ign_coil", e.coil, m_tdata[83]);
          compare_field("ign_delay", e.ign_delay, m_tdata[115:84]);
          compare_field("ign_dwell", e.ign_dwell, m_tdata[147:116]);
          compare_field("zero_fill", 0, m_tdata[151:148]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DECODER_MODE:    mode = cfg_data[0];
          REG_TOOTH_COUNT:     tooth_cnt = cfg_data[7:0];
          REG_MISSING_TEETH:   miss_cnt = cfg_data[3:0];
          REG_EDGES_PER_TOOTH: ept = cfg_data[1:0];
          REG_INJ_MIN_WIDTH:   inj_min = cfg_data;
          REG_INJ_MAX_WIDTH:   inj_max = cfg_data;
          REG_DWELL_MIN_TIME:  dwell_lo = cfg_data;
          REG_DWELL_MAX_TIME:  dwell_hi = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        decode_edge(s_tdata, p);
        schedule_q.push_back(p);
      end
    end
    errors <= err_cnt;
    pending <= schedule_q.size();
  end
endmodule

>>> dv/crank_trigger_decoder_scheduler_core_test.sv
// Top of the crank trigger decoder testbench: clock, reset, stimulus and verdict.
module crank_trigger_decoder_scheduler_core_test;
  import ctd_pkg::*;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors, pending;

  crank_trigger_decoder_scheduler_core dut (.*);
  crank_trigger_decoder_scheduler_checker chk (.*);

  bit [15:0] cur_cfg [8];
  bit [31:0] wheel_time;
  int        sent;
  int        stall_left;
  bit        calm;

  initial forever #1 clk = ~clk;

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      stall_left = 0;
      calm = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_edge(input bit [31:0] etime, input bit [15:0] pw1, input bit [15:0] pw2,
                           input bit [7:0] adv, input bit [15:0] dwell);
    int gap;
    gap = 0;
    if ((sent % 400) >= 100 && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {dwell, adv, pw2, pw1, etime};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_random_fields(input bit [31:0] etime);
    bit [15:0] pw1, pw2, dwell;
    pw1 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25000));
    pw2 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25000));
    dwell = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10000));
    send_edge(etime, pw1, pw2, 8'($urandom), dwell);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_regs(input bit mode, input bit [7:0] tooth, input bit [3:0] miss,
                            input bit [1:0] ept, input bit [15:0] imin, input bit [15:0] imax,
                            input bit [15:0] dmin, input bit [15:0] dmax);
    cur_cfg = '{mode, tooth, miss, ept, imin, imax, dmin, dmax};
    for (int i = 0; i < 8; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= cur_cfg[i];
      cfg_valid <= 1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Whole revolutions of a wheel with random tooth time, plus rejected bounces and jumps.
  task automatic run_wheel(input int count);
    int expct, n, k, tooth_t;
    bit [31:0] t;
    k = 0;
    n = 0;
    tooth_t = 100;
    for (int i = 0; i < count; i++) begin
      if (k >= n) begin
        expct = (cur_cfg[1] > cur_cfg[2]) ? (cur_cfg[1] - cur_cfg[2]) * cur_cfg[3] : 0;
        n = (expct > 2) ? expct - 2 : 0;
        if ($urandom_range(0, 4) == 0) n = n + $urandom_range(0, 30) - 15;
        if (n < 0) n = 0;
        k = -1;
        tooth_t = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 60) : $urandom_range(60, 4000);
      end
      case ($urandom_range(0, 19))
        0: send_random_fields(wheel_time + $urandom_range(0, 49));
        1: begin
          wheel_time = $urandom;
          send_random_fields(wheel_time);
        end
        default: begin
          if (k < n - 1 || k == -1)
            t = tooth_t + $urandom_range(0, tooth_t / 8);
          else
            t = 2 * tooth_t + $urandom_range(1, tooth_t);
          if (k == -1) t = tooth_t;
          wheel_time = wheel_time + t;
          send_random_fields(wheel_time);
          k++;
        end
      endcase
    end
  endtask

  task automatic run_distributor(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random_fields(wheel_time + $urandom_range(0, 499));
      end else begin
        wheel_time = wheel_time + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(500, 40000));
        send_random_fields(wheel_time);
      end
    end
  endtask

  initial begin
    sent = 0;
    cur_cfg = '{0, 36, 1, 2, 500, 20000, 1500, 6000};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_edge(32'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_edge(32'd49, 16'hFFFF, 16'hFFFF, 8'h7F, 16'hFFFF);
    send_edge(32'd50, 16'd1000, 16'd2000, 8'h80, 16'd3000);
    send_edge(32'd100, 16'd1000, 16'd2000, 8'h01, 16'd3000);
    send_edge(32'hFFFF_FFFF, 16'd1000, 16'd2000, 8'hFF, 16'd3000);
    send_edge(32'd60, 16'd1000, 16'd2000, 8'h00, 16'd3000);
    wait_idle();
    write_regs(1, 36, 1, 2, 500, 20000, 1500, 6000);
    send_edge(32'd559, 16'd1000, 16'd0, 8'h00, 16'd0);
    send_edge(32'd560, 16'd1000, 16'd0, 8'h00, 16'd0);
    send_edge(32'd1060, 16'd0, 16'hFFFF, 8'h7F, 16'hFFFF);
    send_edge(32'd21060, 16'hFFFF, 16'd0, 8'h80, 16'd0);
    send_edge(32'd41060, 16'd500, 16'd20000, 8'h01, 16'd6000);
    send_edge(32'd41559, 16'd500, 16'd20000, 8'hFF, 16'd1500);
    send_edge(32'hFFFF_FF00, 16'd499, 16'd20001, 8'h2D, 16'd40000);
    send_edge(32'd500, 16'd1234, 16'd4321, 8'hD3, 16'd100);
    send_edge(32'd1000, 16'd1234, 16'd4321, 8'h0A, 16'd65535);

    wheel_time = -$urandom_range(0, 3000000);
    wait_idle(); write_regs(0, 36, 1, 2, 500, 20000, 1500, 6000); run_wheel(300);
    wait_idle(); write_regs(0, 6, 1, 1, 0, 65535, 0, 65535); run_wheel(250);
    wait_idle(); write_regs(0, 12, 2, 2, 3000, 1000, 8000, 2000); run_wheel(250);
    wait_idle(); write_regs(1, 1, 0, 3, 100, 60000, 65535, 65535); run_distributor(250);
    wait_idle(); write_regs(0, 1, 8, 0, 0, 0, 0, 0); run_wheel(150);
    wheel_time = -$urandom_range(0, 3000000);
    wait_idle(); write_regs(0, 255, 8, 1, 800, 15000, 1000, 9000); run_wheel(300);
    wait_idle(); write_regs(0, 4, 0, 3, 500, 20000, 1500, 6000); run_wheel(200);
    wait_idle(); write_regs(1, 255, 8, 1, 65535, 0, 65535, 0); run_distributor(150);
    wait_idle(); write_regs(0, 8, 1, 2, 200, 30000, 0, 12000); run_wheel(100);

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
